// File: sv/lfuac_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lfu accumulating cache
// no dependencies

package lfuac_pkg;

	localparam int ENTRIES  = 4;
	localparam int KEY_BITS = 16;

	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int KEY_IN_W = 16;
	localparam int DATA_W   = 16;
	localparam int SUM_W    = 32;
	localparam int COUNT_W  = 16;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [COUNT_W-1:0]  count_t;

	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};
	localparam sum_t   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
	localparam idx_t   IDX_LAST  = IDX_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

endpackage

// File: sv/lfu_accumulating_cache.sv
`timescale 1ns / 1ps
// lfu accumulating cache: a small keyed table of running sums and use counts
// depends on lfuac_pkg
//
// usage
//   input channel (in_valid / in_stall) carries one item: a key and a signed data
//   value. the output channel (out_valid / out_stall) returns exactly one item per
//   input item: hit flag, eviction flag with the evicted key and sum, and the
//   requested key's running sum and use count after the update.
// timing
//   after an item is accepted, one compare unit walks the table one entry per
//   cycle, then the update state does the saturating add on a hit (a fresh
//   entry on a miss) and writes the chosen slot. out_valid comes from the output
//   register, loaded as the update state completes. the sequencer then returns
//   to idle before the next accept, so a new item is taken only after the last
//   one is through; in_stall is high while the scan and the update run.
// stall
//   the result is held in the output register until taken. if the previous
//   result is still waiting, the update cycle waits too, so no result is lost.
// reset
//   arst_n clears all entry valid bits (table empty), the sequencer and the
//   output valid flag. key, sum and count storage is not cleared; an entry is
//   only used while its valid bit is set.

module lfu_accumulating_cache (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [lfuac_pkg::KEY_IN_W-1:0]        key,
	input  logic signed [lfuac_pkg::DATA_W-1:0]   data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  hit,
	output logic                                  evicted,
	output logic [lfuac_pkg::KEY_IN_W-1:0]        evicted_key,
	output logic signed [lfuac_pkg::SUM_W-1:0]    evicted_sum,
	output logic signed [lfuac_pkg::SUM_W-1:0]    sum_now,
	output logic [lfuac_pkg::COUNT_W-1:0]         count_now
);

	// table storage; valid bits are reset, payload is not
	logic                  entry_valid_q [lfuac_pkg::ENTRIES];
	lfuac_pkg::key_t       entry_key_q   [lfuac_pkg::ENTRIES];
	lfuac_pkg::sum_t       entry_sum_q   [lfuac_pkg::ENTRIES];
	lfuac_pkg::count_t     entry_count_q [lfuac_pkg::ENTRIES];

	lfuac_pkg::state_t     state_q, state_d;
	lfuac_pkg::idx_t       idx_q;

	// captured request
	lfuac_pkg::key_t       req_key_q;
	logic [lfuac_pkg::DATA_W-1:0] req_data_q;

	// scan results
	logic                  found_q;
	lfuac_pkg::idx_t       found_idx_q;
	lfuac_pkg::sum_t       found_sum_q;
	lfuac_pkg::count_t     found_cnt_q;
	logic                  free_q;
	lfuac_pkg::idx_t       free_idx_q;
	lfuac_pkg::idx_t       vic_idx_q;
	lfuac_pkg::key_t       vic_key_q;
	lfuac_pkg::sum_t       vic_sum_q;
	lfuac_pkg::count_t     vic_cnt_q;

	// output register
	logic                  out_valid_q;
	logic                  hit_q;
	logic                  evicted_q;
	lfuac_pkg::key_t       ev_key_q;
	lfuac_pkg::sum_t       ev_sum_q;
	lfuac_pkg::sum_t       sum_now_q;
	lfuac_pkg::count_t     count_now_q;

	// sequencer controls
	logic                  accept;
	logic                  scan_en;
	logic                  scan_last;
	logic                  update_en;
	logic                  out_free;

	// current scanned entry
	logic                  cur_valid;
	lfuac_pkg::key_t       cur_key;
	lfuac_pkg::sum_t       cur_sum;
	lfuac_pkg::count_t     cur_cnt;
	logic                  cur_match;
	logic                  cur_less;

	// update datapath
	logic [lfuac_pkg::SUM_W:0] sum_ext;
	lfuac_pkg::sum_t       sum_sat;
	lfuac_pkg::count_t     cnt_inc;
	lfuac_pkg::idx_t       slot;
	lfuac_pkg::sum_t       new_sum;
	lfuac_pkg::count_t     new_cnt;
	logic                  do_evict;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfuac_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = lfuac_pkg::ST_SCAN;
			end
			lfuac_pkg::ST_SCAN: begin
				if (idx_q == lfuac_pkg::IDX_LAST)
					state_d = lfuac_pkg::ST_UPDATE;
			end
			lfuac_pkg::ST_UPDATE: begin
				if (out_free)
					state_d = lfuac_pkg::ST_IDLE;
			end
			default: state_d = lfuac_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		accept    = 1'b0;
		scan_en   = 1'b0;
		scan_last = 1'b0;
		update_en = 1'b0;
		unique case (state_q)
			lfuac_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
			end
			lfuac_pkg::ST_SCAN: begin
				scan_en   = 1'b1;
				scan_last = (idx_q == lfuac_pkg::IDX_LAST);
			end
			lfuac_pkg::ST_UPDATE: begin
				update_en = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfuac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one entry a cycle through the shared compare unit
	assign cur_valid = entry_valid_q[idx_q];
	assign cur_key   = entry_key_q[idx_q];
	assign cur_sum   = entry_sum_q[idx_q];
	assign cur_cnt   = entry_count_q[idx_q];
	assign cur_match = cur_valid && (cur_key == req_key_q);
	// least count wins, ties to the smaller key
	assign cur_less  = (cur_cnt < vic_cnt_q) ||
	                   ((cur_cnt == vic_cnt_q) && (cur_key < vic_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (scan_en) begin
				if (!scan_last)
					idx_q <= idx_q + 1'b1;
				if (cur_match && !found_q)
					found_q <= 1'b1;
				if (!cur_valid && !free_q)
					free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_key_q  <= lfuac_pkg::key_t'(key);
			req_data_q <= data;
		end
		if (scan_en) begin
			if (cur_match && !found_q) begin
				found_idx_q <= idx_q;
				found_sum_q <= cur_sum;
				found_cnt_q <= cur_cnt;
			end
			if (!cur_valid && !free_q)
				free_idx_q <= idx_q;
			// victim only matters when every entry is valid
			if (idx_q == '0 || cur_less) begin
				vic_idx_q <= idx_q;
				vic_key_q <= cur_key;
				vic_sum_q <= cur_sum;
				vic_cnt_q <= cur_cnt;
			end
		end
	end

	// update: saturating add on a hit, fresh entry on a miss
	assign sum_ext = {found_sum_q[lfuac_pkg::SUM_W-1], found_sum_q} +
	                 {{(lfuac_pkg::SUM_W + 1 - lfuac_pkg::DATA_W){req_data_q[lfuac_pkg::DATA_W-1]}},
	                  req_data_q};

	always_comb begin
		if (sum_ext[lfuac_pkg::SUM_W] != sum_ext[lfuac_pkg::SUM_W-1])
			sum_sat = sum_ext[lfuac_pkg::SUM_W] ? lfuac_pkg::SUM_MIN : lfuac_pkg::SUM_MAX;
		else
			sum_sat = sum_ext[lfuac_pkg::SUM_W-1:0];
	end

	assign cnt_inc  = (found_cnt_q == lfuac_pkg::COUNT_MAX) ? found_cnt_q : found_cnt_q + 1'b1;
	assign do_evict = !found_q && !free_q;

	always_comb begin
		if (found_q) begin
			slot    = found_idx_q;
			new_sum = sum_sat;
			new_cnt = cnt_inc;
		end else begin
			slot    = free_q ? free_idx_q : vic_idx_q;
			new_sum = {{(lfuac_pkg::SUM_W - lfuac_pkg::DATA_W){req_data_q[lfuac_pkg::DATA_W-1]}},
			           req_data_q};
			new_cnt = lfuac_pkg::count_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lfuac_pkg::ENTRIES; i++)
				entry_valid_q[i] <= 1'b0;
		end else if (update_en) begin
			entry_valid_q[slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (update_en) begin
			entry_key_q[slot]   <= req_key_q;
			entry_sum_q[slot]   <= new_sum;
			entry_count_q[slot] <= new_cnt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (update_en)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (update_en) begin
			hit_q       <= found_q;
			evicted_q   <= do_evict;
			ev_key_q    <= do_evict ? vic_key_q : '0;
			ev_sum_q    <= do_evict ? vic_sum_q : '0;
			sum_now_q   <= new_sum;
			count_now_q <= new_cnt;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign evicted_key = lfuac_pkg::KEY_IN_W'(ev_key_q);
	assign evicted_sum = ev_sum_q;
	assign sum_now     = sum_now_q;
	assign count_now   = count_now_q;

endmodule
